FILE: rtl/mtis_pkg.sv
// ----------------------------------------------------------------------------
// mtis_pkg
// Shared types and constants of the multithreaded issue scheduler.
// ----------------------------------------------------------------------------
package mtis_pkg;

   // Default build-time sizes
   localparam int MAX_THREADS_DEF = 8;
   localparam int WAIT_WIDTH_DEF  = 8;

   // Fixed field widths
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int COUNT_WIDTH     = 32;

   // Per-thread wait state
   typedef enum logic [1:0] {
      KIND_READY = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_STORE = 2'd2,
      KIND_HALT  = 2'd3
   } kind_type;

   // Instruction class of the input beat
   typedef enum logic [1:0] {
      OP_ALU   = 2'd0,
      OP_LOAD  = 2'd1,
      OP_STORE = 2'd2,
      OP_HALT  = 2'd3
   } op_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODE           = 3'd0,
      CSR_THREADS_IN_USE = 3'd1,
      CSR_LOAD_WAIT      = 3'd2,
      CSR_STORE_WAIT     = 3'd3,
      CSR_SWITCH_PENALTY = 3'd4
   } csr_index_type;

   // One result beat
   typedef struct packed {
      logic                   issued;
      logic [2:0]             issue_thread;
      logic [COUNT_WIDTH-1:0] issue_index;
      logic [2:0]             next_thread;
      logic [COUNT_WIDTH-1:0] next_index;
      logic                   all_halted;
      logic [COUNT_WIDTH-1:0] cycle_total;
      logic [COUNT_WIDTH-1:0] issue_total;
   } rsp_type;

endpackage

FILE: rtl/multithread_issue_scheduler.sv
// ----------------------------------------------------------------------------
// multithread_issue_scheduler
// Per-beat thread select of a multithreaded core with blocked and
// fine-grained switching, wait aging and saturating counters.
// ----------------------------------------------------------------------------
// A result beat is registered in the output buffer (main, or skid then main) and shows on rsp_valid.
// Throughput: one request beat per cycle while req_stall is low; the scheduling decision is one pass
//   of logic between the thread state registers and the result register.
// A two-deep result buffer lets a request enter while one result waits.
// Reset (synchronous) loads the register defaults and clears all thread state.
module multithread_issue_scheduler #(
   parameter int MAX_THREADS = mtis_pkg::MAX_THREADS_DEF,
   parameter int WAIT_WIDTH  = mtis_pkg::WAIT_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_op_class,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_issued,
   output logic [2:0]                           rsp_issue_thread,
   output logic [31:0]                          rsp_issue_index,
   output logic [2:0]                           rsp_next_thread,
   output logic [31:0]                          rsp_next_index,
   output logic                                 rsp_all_halted,
   output logic [31:0]                          rsp_cycle_total,
   output logic [31:0]                          rsp_issue_total,
   input  logic                                 csr_we,
   input  logic [mtis_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mtis_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic              accept;
   logic              full;
   mtis_pkg::rsp_type core_rsp;
   mtis_pkg::rsp_type out_rsp;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   mtis_core #(
      .MAX_THREADS (MAX_THREADS),
      .WAIT_WIDTH  (WAIT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op_class  (req_op_class),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (core_rsp)
   );

   mtis_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_rsp),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_rsp)
   );

   // Unpack the result beat
   assign rsp_issued       = out_rsp.issued;
   assign rsp_issue_thread = out_rsp.issue_thread;
   assign rsp_issue_index  = out_rsp.issue_index;
   assign rsp_next_thread  = out_rsp.next_thread;
   assign rsp_next_index   = out_rsp.next_index;
   assign rsp_all_halted   = out_rsp.all_halted;
   assign rsp_cycle_total  = out_rsp.cycle_total;
   assign rsp_issue_total  = out_rsp.issue_total;

endmodule

FILE: rtl/mtis_core.sv
// ----------------------------------------------------------------------------
// mtis_core
// Thread state, configuration registers and the combinational scheduling
// decision: age waits, issue, retire, pick the next thread round-robin.
// ----------------------------------------------------------------------------
module mtis_core #(
   parameter int MAX_THREADS = mtis_pkg::MAX_THREADS_DEF,
   parameter int WAIT_WIDTH  = mtis_pkg::WAIT_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [1:0]                            op_class,
   input  logic                                  csr_we,
   input  logic [mtis_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mtis_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output mtis_pkg::rsp_type                     result
);

   localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CW = $clog2(MAX_THREADS + 1);
   localparam int SW = CW + 1;
   localparam int NW = mtis_pkg::COUNT_WIDTH;

   // Clamp a thread count into 1 .. MAX_THREADS
   function automatic logic [CW-1:0] clamp_count(input logic [3:0] v);
      logic [CW-1:0] r;
      if (v == 4'd0) begin
         r = CW'(1);
      end else if (32'(v) > 32'(MAX_THREADS)) begin
         r = CW'(MAX_THREADS);
      end else begin
         r = CW'(v);
      end
      return r;
   endfunction

   function automatic logic [NW-1:0] sat_inc(input logic [NW-1:0] v);
      return (v == '1) ? v : v + NW'(1);
   endfunction

   // Configuration registers
   logic       mode_ff;
   logic [3:0] tiu_ff;
   logic [7:0] load_wait_ff;
   logic [7:0] store_wait_ff;
   logic [7:0] penalty_cfg_ff;

   // Thread state
   mtis_pkg::kind_type  kind_ff [MAX_THREADS];
   logic [WAIT_WIDTH-1:0] cnt_ff [MAX_THREADS];
   logic [NW-1:0]       idx_ff [MAX_THREADS];
   logic [TW-1:0]       cur_ff;
   logic [NW-1:0]       cur_idx_ff;
   logic [CW-1:0]       live_ff;
   logic [7:0]          pen_ff;
   logic [NW-1:0]       cyc_ff;
   logic [NW-1:0]       iss_ff;

   // Next values
   mtis_pkg::kind_type  kind_in [MAX_THREADS];
   logic [WAIT_WIDTH-1:0] cnt_in [MAX_THREADS];
   logic [TW-1:0]       cur_in;
   logic [NW-1:0]       cur_idx_in;
   logic [CW-1:0]       live_in;
   logic [7:0]          pen_in;
   logic [NW-1:0]       cyc_in;
   logic [NW-1:0]       iss_in;

   logic [CW-1:0]       n_thr;
   logic [WAIT_WIDTH-1:0] lim_load;
   logic [WAIT_WIDTH-1:0] lim_store;
   mtis_pkg::kind_type  kind_age [MAX_THREADS];
   logic [WAIT_WIDTH-1:0] cnt_age [MAX_THREADS];
   logic [MAX_THREADS-1:0] rdy_mask;
   logic [MAX_THREADS-1:0] soon_mask;
   logic [MAX_THREADS-1:0] pick_mask;
   mtis_pkg::kind_type  new_kind;
   logic                run;
   logic                issue;
   logic                found;
   logic [TW-1:0]       sel;
   logic                do_switch;
   logic                restart;
   logic [CW-1:0]       restart_cnt;
   logic [NW-1:0]       idx_inc;

   assign n_thr     = clamp_count(tiu_ff);
   assign lim_load  = WAIT_WIDTH'(load_wait_ff);
   assign lim_store = WAIT_WIDTH'(store_wait_ff);
   assign run       = (live_ff != '0);
   assign restart   = csr_we &&
                      (mtis_pkg::csr_index_type'(csr_index) == mtis_pkg::CSR_THREADS_IN_USE);
   assign restart_cnt = reset ? clamp_count(4'd8) : clamp_count(csr_wdata[3:0]);

   // Map the instruction class to the wait state it leaves
   always_comb begin
      unique case (mtis_pkg::op_type'(op_class))
         mtis_pkg::OP_LOAD:  new_kind = mtis_pkg::KIND_LOAD;
         mtis_pkg::OP_STORE: new_kind = mtis_pkg::KIND_STORE;
         mtis_pkg::OP_HALT:  new_kind = mtis_pkg::KIND_HALT;
         default:            new_kind = mtis_pkg::KIND_READY;
      endcase
   end

   // Age the waits of active threads
   always_comb begin
      for (int t = 0; t < MAX_THREADS; t++) begin
         kind_age[t] = kind_ff[t];
         cnt_age[t]  = cnt_ff[t];
         if (run && (t < int'(n_thr))) begin
            if (kind_ff[t] == mtis_pkg::KIND_LOAD || kind_ff[t] == mtis_pkg::KIND_STORE) begin
               if (cnt_ff[t] == ((kind_ff[t] == mtis_pkg::KIND_LOAD) ? lim_load : lim_store))
               begin
                  kind_age[t] = mtis_pkg::KIND_READY;
                  cnt_age[t]  = '0;
               end else begin
                  cnt_age[t] = cnt_ff[t] + WAIT_WIDTH'(1);
               end
            end
         end
      end
   end

   // Issue when the current thread is ready and no switch penalty runs
   assign issue = run && (pen_ff == 8'd0) && (kind_age[cur_ff] == mtis_pkg::KIND_READY);

   // Apply the issue and build the candidate masks
   always_comb begin
      for (int t = 0; t < MAX_THREADS; t++) begin
         kind_in[t] = kind_age[t];
         cnt_in[t]  = cnt_age[t];
         if (issue && (TW'(t) == cur_ff)) begin
            kind_in[t] = new_kind;
            cnt_in[t]  = '0;
         end
         rdy_mask[t]  = (t < int'(n_thr)) && (kind_in[t] == mtis_pkg::KIND_READY);
         soon_mask[t] = (t < int'(n_thr)) &&
                        ((kind_in[t] == mtis_pkg::KIND_READY) ||
                         ((kind_in[t] == mtis_pkg::KIND_LOAD) && (cnt_in[t] == lim_load)) ||
                         ((kind_in[t] == mtis_pkg::KIND_STORE) && (cnt_in[t] == lim_store)));
      end
   end

   assign pick_mask = mode_ff ? soon_mask : rdy_mask;

   // Round-robin search starting after the current thread; nearest hit wins
   always_comb begin
      logic [SW-1:0] s;
      found = 1'b0;
      sel   = cur_ff;
      for (int i = MAX_THREADS; i >= 1; i--) begin
         s = SW'(cur_ff) + SW'(i);
         if (s >= SW'(n_thr)) begin
            s = s - SW'(n_thr);
         end
         if ((i <= int'(n_thr)) && pick_mask[s[TW-1:0]]) begin
            found = 1'b1;
            sel   = s[TW-1:0];
         end
      end
   end

   assign do_switch = run && (pen_ff == 8'd0) && (mode_ff || !issue) && found;
   assign cur_in    = do_switch ? sel : cur_ff;
   assign idx_inc   = sat_inc(cur_idx_ff);

   // Penalty, index and counter updates
   always_comb begin
      pen_in = pen_ff;
      if (run) begin
         if (pen_ff != 8'd0) begin
            pen_in = pen_ff - 8'd1;
         end else if (!mode_ff && do_switch) begin
            pen_in = (penalty_cfg_ff != 8'd0) ? penalty_cfg_ff - 8'd1 : 8'd0;
         end
      end
      if (cur_in == cur_ff) begin
         cur_idx_in = issue ? idx_inc : cur_idx_ff;
      end else begin
         cur_idx_in = idx_ff[cur_in];
      end
      live_in = (issue && (new_kind == mtis_pkg::KIND_HALT)) ? live_ff - CW'(1) : live_ff;
      cyc_in  = run ? sat_inc(cyc_ff) : cyc_ff;
      iss_in  = issue ? sat_inc(iss_ff) : iss_ff;
   end

   // Result beat
   always_comb begin
      result.issued       = issue;
      result.issue_thread = issue ? 3'(32'(cur_ff)) : 3'd0;
      result.issue_index  = issue ? cur_idx_ff : '0;
      result.next_thread  = 3'(32'(cur_in));
      result.next_index   = cur_idx_in;
      result.all_halted   = (live_in == '0);
      result.cycle_total  = cyc_in;
      result.issue_total  = iss_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         tiu_ff         <= 4'd8;
         load_wait_ff   <= 8'd4;
         store_wait_ff  <= 8'd4;
         penalty_cfg_ff <= 8'd1;
      end else if (csr_we) begin
         unique case (mtis_pkg::csr_index_type'(csr_index))
            mtis_pkg::CSR_MODE:           mode_ff        <= csr_wdata[0];
            mtis_pkg::CSR_THREADS_IN_USE: tiu_ff         <= csr_wdata[3:0];
            mtis_pkg::CSR_LOAD_WAIT:      load_wait_ff   <= csr_wdata;
            mtis_pkg::CSR_STORE_WAIT:     store_wait_ff  <= csr_wdata;
            mtis_pkg::CSR_SWITCH_PENALTY: penalty_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Scheduler state: restart on reset or a thread count write, else advance per beat
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int t = 0; t < MAX_THREADS; t++) begin
            kind_ff[t] <= mtis_pkg::KIND_READY;
            cnt_ff[t]  <= '0;
            idx_ff[t]  <= '0;
         end
         cur_ff     <= '0;
         cur_idx_ff <= '0;
         live_ff    <= restart_cnt;
         pen_ff     <= 8'd0;
         cyc_ff     <= '0;
         iss_ff     <= '0;
      end else if (accept) begin
         for (int t = 0; t < MAX_THREADS; t++) begin
            kind_ff[t] <= kind_in[t];
            cnt_ff[t]  <= cnt_in[t];
         end
         if (issue) begin
            idx_ff[cur_ff] <= idx_inc;
         end
         cur_ff     <= cur_in;
         cur_idx_ff <= cur_idx_in;
         live_ff    <= live_in;
         pen_ff     <= pen_in;
         cyc_ff     <= cyc_in;
         iss_ff     <= iss_in;
      end
   end

endmodule

FILE: rtl/mtis_obuf.sv
// ----------------------------------------------------------------------------
// mtis_obuf
// Result register with a skid stage, so a beat can enter while the
// previous one still waits on a stalled receiver.
// ----------------------------------------------------------------------------
module mtis_obuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mtis_pkg::rsp_type push_data,
   output logic              full,
   output logic              out_valid,
   input  logic              out_stall,
   output mtis_pkg::rsp_type out_data
);

   logic              main_valid_ff;
   logic              skid_valid_ff;
   mtis_pkg::rsp_type main_ff;
   mtis_pkg::rsp_type skid_ff;
   logic              pop;

   assign pop       = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload: drain the skid first, else load the new beat
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (!main_valid_ff || pop) begin
         main_ff <= push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

endmodule

FILE: rtl/mtis_checker.sv
// ----------------------------------------------------------------------------
// mtis_checker
// Port-level checks of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mtis_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_issued,
   input logic [2:0]  rsp_issue_thread,
   input logic [31:0] rsp_issue_index,
   input logic [31:0] rsp_next_index,
   input logic [31:0] rsp_cycle_total,
   input logic [31:0] rsp_issue_total
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_index) &&
                                 $stable(rsp_issue_total))
      else $error("stalled result beat changed");

   // Reset leaves no result beat pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A beat without issue reports thread and index as zero
   a_no_issue_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_issued |-> (rsp_issue_thread == 3'd0) && (rsp_issue_index == 32'd0))
      else $error("issue fields set without an issue");

   // At most one issue per counted cycle
   a_issue_le_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_issue_total <= rsp_cycle_total))
      else $error("issue count exceeds cycle count");

   // An issuing beat has a nonzero issue count
   a_issue_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_issued |-> (rsp_issue_total != 32'd0))
      else $error("issue not counted");

endmodule

bind multithread_issue_scheduler mtis_checker u_mtis_checker (.*);
